### rtl/core/sstf_pkg.sv
// Shared constants, frame type and glyph lookup for the seven-segment text formatter.
`default_nettype none

package sstf_pkg;

    localparam int NUM_DIGITS_DEF = 4;   // default number of stored digits
    localparam int OUT_DIGITS     = 4;   // digit fields on the output word
    localparam int COLON_POS      = 2;   // write position after a colon

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] GLYPH_DASH = 8'h40;
    localparam logic [7:0] GLYPH_BLANK = 8'h00;
    localparam logic [7:0] COLON_BIT  = 8'h80;

    typedef struct packed {
        logic [OUT_DIGITS-1:0][7:0] digit;
    } frame_t;

    // segment a in bit 0 through segment g in bit 6
    function automatic logic [7:0] glyph_of(input logic [7:0] code);
        logic [7:0] g;
        case (code)
            8'h30, 8'h4F:        g = 8'h3F;   // 0 O
            8'h31:               g = 8'h06;
            8'h32, 8'h5A:        g = 8'h5B;   // 2 Z
            8'h33:               g = 8'h4F;
            8'h34:               g = 8'h66;
            8'h35, 8'h53, 8'h73: g = 8'h6D;   // 5 S s
            8'h36:               g = 8'h7D;
            8'h37:               g = 8'h07;
            8'h38:               g = 8'h7F;
            8'h39:               g = 8'h6F;
            8'h41, 8'h61:        g = 8'h77;   // A a
            8'h42, 8'h62:        g = 8'h7C;
            8'h43, 8'h63:        g = 8'h39;
            8'h44, 8'h64:        g = 8'h5E;
            8'h45, 8'h65:        g = 8'h79;
            8'h46, 8'h66:        g = 8'h71;
            8'h47, 8'h67:        g = 8'h3D;
            8'h48:               g = 8'h76;   // H
            8'h68:               g = 8'h74;   // h
            8'h49, 8'h69:        g = 8'h30;
            8'h4A, 8'h6A:        g = 8'h0E;
            8'h4C, 8'h6C:        g = 8'h38;
            8'h4E, 8'h6E:        g = 8'h54;
            8'h6F:               g = 8'h5C;   // o
            8'h50, 8'h70:        g = 8'h73;
            8'h52, 8'h72:        g = 8'h50;
            8'h54, 8'h74:        g = 8'h78;
            8'h55:               g = 8'h3E;   // U
            8'h75:               g = 8'h1C;   // u
            8'h2D:               g = 8'h40;   // -
            8'h5F:               g = 8'h08;   // _
            8'h20:               g = GLYPH_BLANK;
            default:             g = GLYPH_DASH;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

### rtl/core/sstf_frame.sv
// Frame builder: digit store, write position and colon flag, updated one character per cycle while step is high.
`default_nettype none

module sstf_frame
    import sstf_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] char_code,
    output frame_t          frame
);

    localparam int POS_W = $clog2(NUM_DIGITS + 1);
    localparam int IDX_W = $clog2(NUM_DIGITS);
    localparam logic [POS_W-1:0] POS_FULL  = POS_W'(NUM_DIGITS);
    localparam logic [POS_W-1:0] POS_COLON = POS_W'(COLON_POS);

    logic [7:0]       digit_reg  [NUM_DIGITS];
    logic [7:0]       digit_next [NUM_DIGITS];
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             colon_reg, colon_next;

    logic is_nul;
    logic is_colon;
    logic has_room;

    assign is_nul   = (char_code == CHAR_NUL);
    assign is_colon = (char_code == CHAR_COLON);
    assign has_room = (pos_reg < POS_FULL);

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            digit_next[i] = digit_reg[i];
        end
        pos_next   = pos_reg;
        colon_next = colon_reg;
        if (step)
        begin
            if (is_nul)
            begin
                for (int i = 0; i < NUM_DIGITS; i++)
                begin
                    digit_next[i] = GLYPH_BLANK;
                end
                pos_next   = '0;
                colon_next = 1'b0;
            end
            else if (has_room)
            begin
                if (is_colon)
                begin
                    // jumps to digit 2, backwards too; earlier digits stay
                    colon_next = 1'b1;
                    pos_next   = POS_COLON;
                end
                else
                begin
                    digit_next[pos_reg[IDX_W-1:0]] = glyph_of(char_code);
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                digit_reg[i] <= GLYPH_BLANK;
            end
            pos_reg   <= '0;
            colon_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                digit_reg[i] <= digit_next[i];
            end
            pos_reg   <= pos_next;
            colon_reg <= colon_next;
        end
    end

    // output view of the current frame; missing digits read blank
    for (genvar j = 0; j < OUT_DIGITS; j++)
    begin : g_out
        if (j >= NUM_DIGITS)
        begin : g_blank
            assign frame.digit[j] = GLYPH_BLANK;
        end
        else if (j == 1)
        begin : g_colon
            assign frame.digit[j] = digit_reg[j] | (colon_reg ? COLON_BIT : GLYPH_BLANK);
        end
        else
        begin : g_digit
            assign frame.digit[j] = digit_reg[j];
        end
    end

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_FULL)
        else $error("write position past frame end");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        step && is_nul |=> pos_reg == '0 && !colon_reg)
        else $error("frame state not cleared after NUL");

    a_colon: assert property (@(posedge clk) disable iff (!rst_n)
        step && is_colon && has_room |=> pos_reg == POS_COLON && colon_reg)
        else $error("colon did not move write position");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        step && !is_nul && !has_room |=> $stable(pos_reg) && $stable(colon_reg))
        else $error("full frame changed on non-NUL character");

endmodule

`default_nettype wire

### rtl/core/seven_segment_text_formatter_top.sv
// Top level of the seven-segment text formatter: input register, frame builder, output register.
//
// Usage:
//   Characters arrive on the char channel (char_valid/char_ready, char_code), one byte
//   per word. Each byte is drawn into the next digit (a dash if unknown); a colon sets the
//   colon mark and moves the write position to digit 2; once the frame is full, bytes
//   are dropped until NUL. A NUL byte emits one frame word on the frame channel
//   (frame_valid/frame_ready, digit0..digit3) and clears the frame for the next string.
//   Other bytes produce no output word.
// Path: an accepted NUL waits in the input register until the output register is free,
//   then its frame is loaded there and the frame word is offered on the frame channel.
// Throughput: one character per cycle, unless a NUL waits on an occupied output register;
//   limited by the single glyph lookup and position update between the two registers.
// Reset: rst_n clears both valid flags and the frame to blank, position 0, no colon.
// Stall: while the output word waits, non-NUL characters keep flowing; a NUL in the
//   input register holds until the output register is free, and char_ready drops.
`default_nettype none

module seven_segment_text_formatter_top
    import sstf_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       char_valid,
    output logic            char_ready,
    input  wire logic [7:0] char_code,
    output logic            frame_valid,
    input  wire logic       frame_ready,
    output logic [7:0]      digit0,
    output logic [7:0]      digit1,
    output logic [7:0]      digit2,
    output logic [7:0]      digit3
);

    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       out_valid_reg;
    frame_t     out_reg;
    frame_t     frame;

    logic is_nul;
    logic out_free;
    logic advance;

    assign is_nul     = (char_reg == CHAR_NUL);
    assign out_free   = !out_valid_reg || frame_ready;
    assign advance    = in_valid_reg && (!is_nul || out_free);
    assign char_ready = !in_valid_reg || advance;

    sstf_frame #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .char_code (char_reg),
        .frame     (frame)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (char_ready)
        begin
            in_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid)
        begin
            char_reg <= char_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && is_nul)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (frame_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_nul)
        begin
            out_reg <= frame;
        end
    end

    assign frame_valid = out_valid_reg;
    assign digit0      = out_reg.digit[0];
    assign digit1      = out_reg.digit[1];
    assign digit2      = out_reg.digit[2];
    assign digit3      = out_reg.digit[3];

    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_nul |=> out_valid_reg)
        else $error("NUL word did not load output register");

    a_nul_block: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && is_nul && out_valid_reg && !frame_ready |-> !char_ready && !advance)
        else $error("NUL advanced over a waiting output word");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !is_nul |-> char_ready)
        else $error("non-NUL character stalled");

endmodule

`default_nettype wire

### dv/sstf_frame_monitor.sv
// Channel monitor for the seven-segment text formatter: predicts frames and compares them.
`default_nettype none

module sstf_frame_monitor
    import sstf_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       char_valid,
    input  wire logic       char_ready,
    input  wire logic [7:0] char_code,
    input  wire logic       frame_valid,
    input  wire logic       frame_ready,
    input  wire logic [7:0] digit0,
    input  wire logic [7:0] digit1,
    input  wire logic [7:0] digit2,
    input  wire logic [7:0] digit3,
    output int              mismatch_count,
    output int              frames_pending,
    output int              frames_checked
);

    logic [7:0]  shown [NUM_DIGITS];
    int unsigned cursor;
    logic        colon_flag;
    frame_t      frame_queue [$];
    int          errors;
    int          checked;

    function automatic logic [7:0] segments_for(input logic [7:0] ch);
        logic [7:0] seg;
        case (ch)
            "0", "O":      seg = 8'h3F;
            "1":           seg = 8'h06;
            "2", "Z":      seg = 8'h5B;
            "3":           seg = 8'h4F;
            "4":           seg = 8'h66;
            "5", "S", "s": seg = 8'h6D;
            "6":           seg = 8'h7D;
            "7":           seg = 8'h07;
            "8":           seg = 8'h7F;
            "9":           seg = 8'h6F;
            "A", "a":      seg = 8'h77;
            "B", "b":      seg = 8'h7C;
            "C", "c":      seg = 8'h39;
            "D", "d":      seg = 8'h5E;
            "E", "e":      seg = 8'h79;
            "F", "f":      seg = 8'h71;
            "G", "g":      seg = 8'h3D;
            "H":           seg = 8'h76;
            "h":           seg = 8'h74;
            "I", "i":      seg = 8'h30;
            "J", "j":      seg = 8'h0E;
            "L", "l":      seg = 8'h38;
            "N", "n":      seg = 8'h54;
            "o":           seg = 8'h5C;
            "P", "p":      seg = 8'h73;
            "R", "r":      seg = 8'h50;
            "T", "t":      seg = 8'h78;
            "U":           seg = 8'h3E;
            "u":           seg = 8'h1C;
            "-":           seg = 8'h40;
            "_":           seg = 8'h08;
            " ":           seg = GLYPH_BLANK;
            default:       seg = GLYPH_DASH;
        endcase
        return seg;
    endfunction

    task automatic clear_text();
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            shown[i] = GLYPH_BLANK;
        end
        cursor     = 0;
        colon_flag = 1'b0;
    endtask

    // one accepted character; a NUL queues the frame it closes
    task automatic take_char(input logic [7:0] ch);
        frame_t f;
        if (ch == CHAR_NUL)
        begin
            f = '0;
            for (int j = 0; j < OUT_DIGITS; j++)
            begin
                if (j < NUM_DIGITS)
                    f.digit[j] = shown[j];
            end
            if (colon_flag)
                f.digit[1] = f.digit[1] | COLON_BIT;
            frame_queue.push_back(f);
            clear_text();
        end
        else if (cursor < NUM_DIGITS)
        begin
            // a full frame drops everything up to NUL, colons too
            if (ch == CHAR_COLON)
            begin
                colon_flag = 1'b1;
                cursor     = COLON_POS;
            end
            else
            begin
                shown[cursor] = segments_for(ch);
                cursor        = cursor + 1;
            end
        end
    endtask

    task automatic check_frame(input frame_t got);
        frame_t want;
        if (frame_queue.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("%0t: frame word with none expected: %h %h %h %h", $realtime,
                         got.digit[0], got.digit[1], got.digit[2], got.digit[3]);
        end
        else
        begin
            want = frame_queue.pop_front();
            checked++;
            for (int j = 0; j < OUT_DIGITS; j++)
            begin
                if (got.digit[j] !== want.digit[j])
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: digit%0d mismatch, expected %h, got %h", $realtime,
                                 j, want.digit[j], got.digit[j]);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_t got;
        if (!rst_n)
        begin
            clear_text();
            frame_queue.delete();
            errors  = 0;
            checked = 0;
        end
        else
        begin
            if (char_valid && char_ready)
                take_char(char_code);
            if (frame_valid && frame_ready)
            begin
                got.digit[0] = digit0;
                got.digit[1] = digit1;
                got.digit[2] = digit2;
                got.digit[3] = digit3;
                check_frame(got);
            end
        end
        mismatch_count <= errors;
        frames_pending <= frame_queue.size();
        frames_checked <= checked;
    end

endmodule

`default_nettype wire

### dv/seven_segment_text_formatter_top_tb.sv
// Testbench top for the seven-segment text formatter: clock, reset, traffic and verdict.
`default_nettype none

module seven_segment_text_formatter_top_tb;
    import sstf_pkg::*;

    localparam int CHAR_TARGET = 1730;
    localparam int LONG_HOLD   = 300;

    localparam int RX_ALWAYS = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_BURSTY = 3;

    logic       clk;
    logic       rst_n;
    logic       char_valid;
    logic       char_ready;
    logic [7:0] char_code;
    logic       frame_valid;
    logic       frame_ready;
    logic [7:0] digit0;
    logic [7:0] digit1;
    logic [7:0] digit2;
    logic [7:0] digit3;
    logic       hold_off_req;

    int mismatch_count;
    int frames_pending;
    int frames_checked;

    int sent_chars;
    int sent_nuls;
    int sent_colons;
    int burst_left;

    string glyph_chars = "0123456789OZSsAaBbCcDdEeFfGgHhIiJjLlNnoPpRrTtUu-_ ";

    seven_segment_text_formatter_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_code   (char_code),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .digit0      (digit0),
        .digit1      (digit1),
        .digit2      (digit2),
        .digit3      (digit3)
    );

    sstf_frame_monitor monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_valid     (char_valid),
        .char_ready     (char_ready),
        .char_code      (char_code),
        .frame_valid    (frame_valid),
        .frame_ready    (frame_ready),
        .digit0         (digit0),
        .digit1         (digit1),
        .digit2         (digit2),
        .digit3         (digit3),
        .mismatch_count (mismatch_count),
        .frames_pending (frames_pending),
        .frames_checked (frames_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

    // sends one word, then maybe idles the channel before the next burst
    task automatic send_byte(input logic [7:0] b);
        char_valid <= 1'b1;
        char_code  <= b;
        @(posedge clk);
        while (!char_ready)
            @(posedge clk);
        sent_chars++;
        if (b == CHAR_NUL)
            sent_nuls++;
        if (b == CHAR_COLON)
            sent_colons++;
        burst_left--;
        if (burst_left <= 0)
        begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 20);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    // mostly short valid strings with an optional colon; the rest is noise,
    // overlong strings and strings that run on without a NUL
    task automatic send_phrase();
        int kind;
        int len;
        int colon_at;
        kind = $urandom_range(0, 9);
        if (kind <= 6)
        begin
            len      = $urandom_range(0, 5);
            colon_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len) : -1;
            for (int i = 0; i <= len; i++)
            begin
                if (i == colon_at)
                    send_byte(CHAR_COLON);
                if (i < len)
                    send_byte(glyph_chars[$urandom_range(0, glyph_chars.len() - 1)]);
            end
        end
        else
        begin
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_byte(CHAR_COLON);
                else
                    send_byte(8'($urandom_range(1, 255)));
            end
        end
        if (kind != 9)
            send_byte(CHAR_NUL);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        char_valid   = 1'b0;
        char_code    = CHAR_NUL;
        hold_off_req = 1'b0;
        sent_chars   = 0;
        sent_nuls    = 0;
        sent_colons  = 0;
        burst_left   = 12;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty string
        send_byte(CHAR_NUL);
        // byte extremes, all unknown so all dashes
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h01);
        send_byte(CHAR_NUL);
        // colon mid string
        send_text("12:3");
        send_byte(CHAR_NUL);
        // colon first jumps straight to digit 2
        send_text(":A");
        send_byte(CHAR_NUL);
        // full frame drops the colon and the extra glyph
        send_text("abcd:x");
        send_byte(CHAR_NUL);
        // colon moves the position back from 3 to 2
        send_text("hEL:");
        send_byte(CHAR_NUL);

        while (sent_chars < CHAR_TARGET)
        begin
            if (sent_chars > 600 && !hold_off_req)
                hold_off_req <= 1'b1;
            send_phrase();
        end
        send_byte(CHAR_NUL);
        char_valid <= 1'b0;

        repeat (2) @(posedge clk);
        while (frames_pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        $display("Run covered %0d characters with %0d string ends and %0d colons.",
                 sent_chars, sent_nuls, sent_colons);
        $display("%0d frames compared, including one %0d-cycle output stall.",
                 frames_checked, LONG_HOLD);
        if (mismatch_count == 0 && frames_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        int  rx_cycle;
        int  rx_mode;
        bit  hold_done;
        frame_ready = 1'b0;
        rx_cycle    = 0;
        rx_mode     = RX_COIN;
        hold_done   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (hold_off_req && !hold_done)
            begin
                // long stall so NULs back up and the input side stops
                hold_done = 1'b1;
                frame_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if (rx_cycle % 80 == 0)
                    rx_mode = $urandom_range(RX_ALWAYS, RX_BURSTY);
                case (rx_mode)
                    RX_ALWAYS: frame_ready <= 1'b1;
                    RX_COIN:   frame_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: frame_ready <= ($urandom_range(0, 3) == 0);
                    default:   frame_ready <= rx_cycle[3];
                endcase
            end
        end
    end

endmodule

`default_nettype wire

### filelist.f
rtl/core/sstf_pkg.sv
rtl/core/sstf_frame.sv
rtl/core/seven_segment_text_formatter_top.sv
dv/sstf_frame_monitor.sv
dv/seven_segment_text_formatter_top_tb.sv
